// ===== hw/rtl/sync_header_frame_parser_defines.svh =====
// Assertion macros used by the frame parser core (shfp_core).
`ifndef SYNC_HEADER_FRAME_PARSER_DEFINES_SVH
`define SYNC_HEADER_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SHFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("shfp assertion failed");

// Next-cycle implication, checked out of reset.
`define SHFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("shfp assertion failed");

`endif

// ===== hw/rtl/shfp_pkg.sv =====
// Types and constants of the sync-header frame parser.
package shfp_pkg;

  localparam logic [7:0] SYNC_U   = 8'h55;
  localparam logic [7:0] SYNC_N   = 8'h4E;
  localparam logic [7:0] SYNC_E   = 8'h45;
  localparam logic [7:0] SYNC_R   = 8'h52;
  localparam logic [7:0] TOKEN_CH = 8'h3A;

  // Fixed part of the checksum: sync bytes and token.
  localparam logic [7:0] HDR_XOR = SYNC_U ^ SYNC_N ^ SYNC_E ^ SYNC_R ^ TOKEN_CH;

  typedef enum logic [2:0] {
    PH_SEEK_U  = 3'd0,
    PH_EXP_N   = 3'd1,
    PH_EXP_E   = 3'd2,
    PH_EXP_R   = 3'd3,
    PH_LEN     = 3'd4,
    PH_TOKEN   = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_payload;
    logic       is_command;
    logic       frame_end;
    logic       frame_ok;
  } shfp_result_t;

endpackage

// ===== hw/rtl/shfp_ifs.sv =====
// Valid/ready channel interfaces for received bytes and parse results.
interface shfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface shfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_payload;
  logic       is_command;
  logic       frame_end;
  logic       frame_ok;

  modport source (output valid, output data_byte, output is_payload, output is_command,
                  output frame_end, output frame_ok, input ready);
  modport sink   (input valid, input data_byte, input is_payload, input is_command,
                  input frame_end, input frame_ok, output ready);
endinterface

// ===== hw/rtl/shfp_in_stage.sv =====
// Input register: captures one received word and holds it until the parser takes it.
module shfp_in_stage (
  input  logic        clk,
  input  logic        rst_n,
  shfp_in_if.sink     in_ch,
  input  logic        advance,
  output logic        byte_valid,
  output logic [7:0]  byte_q
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    priority if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_q     = byte_r;

endmodule

// ===== hw/rtl/shfp_core.sv =====
// Frame parser state machine: phase, length count, running checksum, result flags.
`include "sync_header_frame_parser_defines.svh"

module shfp_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  output shfp_pkg::shfp_result_t result
);

  shfp_pkg::phase_t phase_r, phase_nxt, restart;
  logic [7:0]       bytes_left_r, bytes_left_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic             pending_r, pending_nxt;
  logic [7:0]       cnt_dec;

  assign cnt_dec = bytes_left_r - 8'd1;
  // A mismatching byte is retried as a fresh 'U'.
  assign restart = (rx_byte == shfp_pkg::SYNC_U) ? shfp_pkg::PH_EXP_N : shfp_pkg::PH_SEEK_U;

  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    xor_nxt        = xor_r;
    pending_nxt    = pending_r;
    unique case (phase_r)
      shfp_pkg::PH_SEEK_U: begin
        phase_nxt = restart;
      end
      shfp_pkg::PH_EXP_N: begin
        phase_nxt = (rx_byte == shfp_pkg::SYNC_N) ? shfp_pkg::PH_EXP_E : restart;
      end
      shfp_pkg::PH_EXP_E: begin
        phase_nxt = (rx_byte == shfp_pkg::SYNC_E) ? shfp_pkg::PH_EXP_R : restart;
      end
      shfp_pkg::PH_EXP_R: begin
        phase_nxt = (rx_byte == shfp_pkg::SYNC_R) ? shfp_pkg::PH_LEN : restart;
      end
      shfp_pkg::PH_LEN: begin
        bytes_left_nxt = rx_byte;
        phase_nxt      = shfp_pkg::PH_TOKEN;
      end
      shfp_pkg::PH_TOKEN: begin
        if (rx_byte == shfp_pkg::TOKEN_CH) begin
          phase_nxt   = shfp_pkg::PH_PAYLOAD;
          xor_nxt     = shfp_pkg::HDR_XOR ^ bytes_left_r;
          pending_nxt = 1'b1;
        end else begin
          phase_nxt = restart;
        end
      end
      shfp_pkg::PH_PAYLOAD: begin
        // Length zero wraps here and counts as 256.
        bytes_left_nxt = cnt_dec;
        pending_nxt    = 1'b0;
        if (cnt_dec != 8'd0) begin
          xor_nxt = xor_r ^ rx_byte;
        end else begin
          phase_nxt = shfp_pkg::PH_SEEK_U;
        end
      end
      default: begin
        phase_nxt = shfp_pkg::PH_SEEK_U;
      end
    endcase
  end

  always_comb begin
    result            = '0;
    result.data_byte  = rx_byte;
    if (phase_r == shfp_pkg::PH_PAYLOAD) begin
      if (cnt_dec != 8'd0) begin
        result.is_payload = 1'b1;
        result.is_command = pending_r;
      end else begin
        result.frame_end = 1'b1;
        result.frame_ok  = (rx_byte == xor_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= shfp_pkg::PH_SEEK_U;
      bytes_left_r <= 8'd0;
      xor_r        <= 8'd0;
      pending_r    <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      xor_r        <= xor_nxt;
      pending_r    <= pending_nxt;
    end
  end

  `SHFP_ASSERT_NEXT(a_token_opens_payload, clk, rst_n, step && phase_r == shfp_pkg::PH_TOKEN && rx_byte == shfp_pkg::TOKEN_CH, phase_r == shfp_pkg::PH_PAYLOAD && pending_r)
  `SHFP_ASSERT_NEXT(a_end_returns_to_seek, clk, rst_n, step && result.frame_end, phase_r == shfp_pkg::PH_SEEK_U && !pending_r)
  `SHFP_ASSERT_NOW(a_command_only_in_payload, clk, rst_n, result.is_command, result.is_payload && !result.frame_end)
  `SHFP_ASSERT_NOW(a_pending_only_in_payload, clk, rst_n, pending_r, phase_r == shfp_pkg::PH_PAYLOAD)

endmodule

// ===== hw/rtl/shfp_out_stage.sv =====
// Result register: holds one parse result until the downstream side takes it.
module shfp_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  shfp_out_if.source            out_ch,
  input  logic                  load,
  input  shfp_pkg::shfp_result_t result,
  output logic                  space
);

  logic                   valid_r, valid_nxt;
  shfp_pkg::shfp_result_t res_r;

  assign space = !valid_r || out_ch.ready;

  always_comb begin
    priority if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.data_byte  = res_r.data_byte;
  assign out_ch.is_payload = res_r.is_payload;
  assign out_ch.is_command = res_r.is_command;
  assign out_ch.frame_end  = res_r.frame_end;
  assign out_ch.frame_ok   = res_r.frame_ok;

endmodule

// ===== hw/rtl/sync_header_frame_parser.sv =====
// Sync-header frame parser top level: input register, parser, result register.
// Path: a word accepted into the input register is parsed, then held in the result register until taken.
// Throughput: one word per cycle while the result register is not stalled; the parser state updates once per word.
// A stalled result register holds the input register, which then drops ready.
// Reset (synchronous, rst_n low) empties both registers and returns to seeking 'U'.
module sync_header_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  shfp_in_if.sink     in_ch,
  shfp_out_if.source  out_ch
);

  logic                   byte_valid;
  logic [7:0]             byte_q;
  logic                   space;
  logic                   advance;
  shfp_pkg::shfp_result_t result;

  assign advance = byte_valid && space;

  shfp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  shfp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (byte_q),
    .result  (result)
  );

  shfp_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .out_ch (out_ch),
    .load   (advance),
    .result (result),
    .space  (space)
  );

endmodule
